@@ hdl/nsfv_pkg.sv @@
// nsfv_pkg: shared types, constants and command codes of the frame validator
// no dependencies
package nsfv_pkg;

    localparam int unsigned MaxModeDefault = 2;
    localparam logic [31:0] TimeoutReset   = 32'd90000;
    localparam int unsigned FrameLen       = 20;

    typedef enum logic [1:0] {
        FUNC_BYTE = 2'd0,
        FUNC_TICK = 2'd1,
        FUNC_TAKE = 2'd2,
        FUNC_NONE = 2'd3
    } t_func;

    localparam logic [2:0] ST_INVALID = 3'd0;
    localparam logic [2:0] ST_READY   = 3'd1;
    localparam logic [2:0] ST_STOPPED = 3'd2;
    localparam logic [2:0] ST_FIX     = 3'd3;
    localparam logic [2:0] ST_TAKEN   = 3'd4;

    localparam logic [7:0] TYPE_START = 8'd8;
    localparam logic [7:0] TYPE_FIX   = 8'd9;
    localparam logic [7:0] TYPE_STOP  = 8'd11;

    localparam logic [7:0] VER_1 = 8'h01;
    localparam logic [7:0] VER_2 = 8'h02;

    // work item handed from front to back
    typedef struct packed {
        t_func       func;
        logic [4:0]  len;
        logic [31:0] route;
        logic        busy;
        logic [31:0] now;
        logic        link;
        logic [159:0] frame;
    } t_cmd;

endpackage

@@ hdl/nsfv_front.sv @@
// nsfv_front: assembles frame bytes and length, emits commands
// depends on nsfv_pkg
module nsfv_front
    import nsfv_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    output logic         o_full,
    input  logic [1:0]   i_func,
    input  logic [7:0]   i_data_byte,
    input  logic         i_last_byte,
    input  logic [31:0]  i_route,
    input  logic         i_busy_req,
    input  logic [31:0]  i_now,
    input  logic         i_link_active,
    output logic         o_cmd_valid,
    output t_cmd         o_cmd,
    input  logic         i_cmd_full
);

    logic [7:0]  r_buf [FrameLen];
    logic [4:0]  r_cnt;
    logic        in_room;
    logic [4:0]  n_len;
    logic        fire;

    assign o_full = i_cmd_full;
    assign fire   = i_push && !i_cmd_full;
    assign in_room = (r_cnt < 5'(FrameLen));
    assign n_len   = (r_cnt == 5'd31) ? 5'd31 : r_cnt + 5'd1;

    always_ff @(posedge i_clk) begin
        if (fire && t_func'(i_func) == FUNC_BYTE && in_room) begin
            r_buf[r_cnt] <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
        end else if (fire && t_func'(i_func) == FUNC_BYTE) begin
            if (i_last_byte) begin
                r_cnt   <= '0;
            end else begin
                r_cnt   <= n_len;
            end
        end
    end

    always_comb begin
        o_cmd.func  = t_func'(i_func);
        o_cmd.len   = n_len;
        o_cmd.route = i_route;
        o_cmd.busy  = i_busy_req;
        o_cmd.now   = i_now;
        o_cmd.link  = i_link_active;
        for (int k = 0; k < FrameLen; k++) begin
            // current byte bypasses the buffer
            if (in_room && r_cnt == 5'(k)) o_cmd.frame[8*k +: 8] = i_data_byte;
            else                           o_cmd.frame[8*k +: 8] = r_buf[k];
        end
        o_cmd_valid = 1'b0;
        if (fire) begin
            unique case (t_func'(i_func))
                FUNC_BYTE: o_cmd_valid = i_last_byte;
                FUNC_TICK, FUNC_TAKE: o_cmd_valid = 1'b1;
                default:   o_cmd_valid = 1'b0;
            endcase
        end
    end

endmodule

@@ hdl/nsfv_queue.sv @@
// nsfv_queue: two-entry queue of commands between front and back
// depends on nsfv_pkg
module nsfv_queue
    import nsfv_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_rd
);

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr) r_q[r_wp] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_wr) r_wp <= ~r_wp;
            if (i_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_wr) - 2'(i_rd);
        end
    end

endmodule

@@ hdl/nsfv_back.sv @@
// nsfv_back: validates commands, updates the session, holds the one-entry result register
// depends on nsfv_pkg
module nsfv_back
    import nsfv_pkg::*;
#(
    parameter int unsigned MAX_MODE = MaxModeDefault
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  t_cmd         i_cmd,
    output logic         o_rd,
    input  logic [31:0]  i_timeout,
    input  logic         i_pop,
    output logic         o_empty,
    output logic [2:0]   o_status_code,
    output logic [31:0]  o_status_id,
    output logic [15:0]  o_status_sequence,
    output logic         o_position_valid,
    output logic [30:0]  o_latitude,
    output logic [31:0]  o_longitude,
    output logic [5:0]   o_accuracy,
    output logic         o_off_route,
    output logic         o_force_refresh,
    output logic [1:0]   o_refresh_mode
);

    localparam logic [1:0] ModeDef = 2'(MAX_MODE);

    logic [159:0] r_fix;
    logic r_act, r_fixp, r_pend;
    logic [1:0]  r_mode;
    logic [31:0] r_sess, r_route, r_stop, r_last;
    logic r_ov;

    logic [159:0] n_fix;
    logic n_act, n_fixp, n_pend;
    logic [1:0]  n_mode;
    logic [31:0] n_sess, n_route, n_stop, n_last;

    logic [2:0]  code;
    logic [31:0] id;
    logic [15:0] seq;
    logic        force_v;
    logic [7:0]  b [FrameLen];
    logic [4:0]  n;
    logic        go;
    logic signed [31:0] lat, lon;
    logic [15:0] acc, age, adv;
    logic        pv;

    assign o_empty = !r_ov;
    assign go = i_valid && (!r_ov || i_pop);
    assign o_rd = go;

    always_comb begin
        for (int k = 0; k < FrameLen; k++) b[k] = i_cmd.frame[8*k +: 8];
        n = i_cmd.len;
        n_fix = r_fix; n_act = r_act; n_fixp = r_fixp; n_pend = r_pend;
        n_mode = r_mode; n_sess = r_sess; n_route = r_route; n_stop = r_stop;
        n_last = r_last;
        code = ST_INVALID; id = '0; seq = '0; force_v = 1'b0;
        lat = $signed({b[10], b[9], b[8], b[7]});
        lon = $signed({b[14], b[13], b[12], b[11]});
        acc = {b[16], b[15]};
        age = {b[18], b[17]};
        adv = '0;
        case (i_cmd.func)
            FUNC_BYTE: begin
                if (n >= 5'd5) begin
                    if (b[0] == TYPE_START) begin
                        if (n >= 5'd10) id = {b[9], b[8], b[7], b[6]};
                    end else begin
                        id = {b[4], b[3], b[2], b[1]};
                    end
                end
                if (n >= 5'd7 && b[0] == TYPE_FIX) seq = {b[6], b[5]};
                adv = seq - r_fix[47:40] - {r_fix[55:48], 8'd0};
                if (id == '0) begin
                    code = ST_INVALID;
                end else if (b[0] == TYPE_START) begin
                    logic okv;
                    logic [1:0] md;
                    okv = 1'b0; md = ModeDef;
                    if (n == 5'd10) okv = (b[1] == VER_1);
                    else if (n == 5'd11) begin
                        okv = (b[1] == VER_2) && (b[10] <= 8'(MAX_MODE));
                        md = b[10][1:0];
                    end
                    if (!okv || i_cmd.route == '0 || {b[5], b[4], b[3], b[2]} != i_cmd.route
                        || i_cmd.busy) begin
                        code = ST_INVALID;
                    end else if (r_act) begin
                        code = (id == r_sess && i_cmd.route == r_route) ? ST_READY : ST_INVALID;
                    end else if (id == r_sess || id == r_stop) begin
                        code = ST_INVALID;
                    end else begin
                        n_sess = id; n_route = i_cmd.route; n_act = 1'b1; n_fixp = 1'b0;
                        n_mode = md; n_last = i_cmd.now; code = ST_READY;
                    end
                end else if (b[0] == TYPE_STOP) begin
                    if (n != 5'd5) code = ST_INVALID;
                    else if (!r_act && id == r_stop) code = ST_STOPPED;
                    else if (!r_act || id != r_sess) code = ST_INVALID;
                    else begin
                        n_stop = id; n_act = 1'b0; n_fixp = 1'b0; n_pend = 1'b0;
                        n_mode = ModeDef; code = ST_STOPPED;
                    end
                end else if (b[0] != TYPE_FIX || n != 5'd20 || !r_act || id != r_sess
                             || i_cmd.busy) begin
                    code = ST_INVALID;
                end else if (i_cmd.route != r_route) begin
                    n_act = 1'b0; n_fixp = 1'b0; n_pend = 1'b0; n_mode = ModeDef;
                end else if (lat < -32'sd900000000 || lat > 32'sd900000000
                             || lon < -32'sd1800000000 || lon > 32'sd1800000000
                             || acc < 16'd1 || acc > 16'd50 || age > 16'd15000
                             || b[19] > 8'd3) begin
                    code = ST_INVALID;
                end else if (r_fixp && adv == '0) begin
                    // a repeat is accepted only if it equals the stored fix byte for byte
                    code = (i_cmd.frame == r_fix) ? ST_FIX : ST_INVALID;
                end else if (r_fixp && adv[15]) begin
                    code = ST_INVALID;
                end else begin
                    n_fix = i_cmd.frame; n_fixp = 1'b1; n_pend = b[19][1];
                    n_last = i_cmd.now; code = ST_FIX;
                end
            end
            FUNC_TICK: begin
                if (r_act && !i_cmd.link && (i_cmd.now - r_last) >= i_timeout) begin
                    n_act = 1'b0; n_fixp = 1'b0; n_pend = 1'b0; n_mode = ModeDef;
                end
            end
            FUNC_TAKE: begin
                code = ST_TAKEN; force_v = r_pend; n_pend = 1'b0;
            end
            default: ;
        endcase
        // position uses the state after this command
        pv = n_act && n_fixp && i_cmd.link;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0; r_fixp <= 1'b0; r_pend <= 1'b0; r_mode <= ModeDef;
            r_sess <= '0; r_route <= '0; r_stop <= '0; r_last <= '0; r_ov <= 1'b0;
        end else begin
            if (go) begin
                r_act <= n_act; r_fixp <= n_fixp; r_pend <= n_pend; r_mode <= n_mode;
                r_sess <= n_sess; r_route <= n_route; r_stop <= n_stop; r_last <= n_last;
            end
            if (go) r_ov <= 1'b1;
            else if (i_pop) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_fix             <= n_fix;
            o_status_code     <= code;
            o_status_id       <= id;
            o_status_sequence <= seq;
            o_position_valid  <= pv;
            o_latitude        <= pv ? n_fix[86:56] : '0;
            o_longitude       <= pv ? n_fix[119:88] : '0;
            o_accuracy        <= pv ? n_fix[125:120] : '0;
            o_off_route       <= pv ? n_fix[152] : 1'b0;
            o_force_refresh   <= force_v;
            o_refresh_mode    <= n_mode;
        end
    end

endmodule

@@ hdl/nav_session_frame_validator.sv @@
// nav_session_frame_validator: top level, config register and the three parts
// depends on nsfv_pkg, nsfv_front, nsfv_queue, nsfv_back
//
// channel  | direction | handshake
// input    | in        | i_push / o_full
// result   | out       | o_empty / i_pop
// config   | in        | APB psel/penable/pwrite, pready always high
//
// one item per cycle unless o_full; a frame byte is absorbed in its cycle,
// commands pass a two-entry queue and the validator registers one result a
// cycle, as its command leaves the queue, into a one-entry output register
// when empty or popped. reset is synchronous and needs no clearing pass.
module nav_session_frame_validator
    import nsfv_pkg::*;
#(
    parameter int unsigned MAX_MODE = MaxModeDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic [31:0] i_route,
    input  logic        i_busy_req,
    input  logic [31:0] i_now,
    input  logic        i_link_active,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [2:0]  o_status_code,
    output logic [31:0] o_status_id,
    output logic [15:0] o_status_sequence,
    output logic        o_position_valid,
    output logic [30:0] o_latitude,
    output logic [31:0] o_longitude,
    output logic [5:0]  o_accuracy,
    output logic        o_off_route,
    output logic        o_force_refresh,
    output logic [1:0]  o_refresh_mode,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0]  r_timeout;
    logic         cmd_valid, q_full, q_valid, q_rd;
    t_cmd         cmd, q_cmd;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? r_timeout : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_timeout <= TimeoutReset;
        else if (psel && penable && pwrite && paddr == 2'd0) r_timeout <= pwdata;
    end

    nsfv_front u_front (
        .i_clk, .i_rst_n, .i_push, .o_full, .i_func, .i_data_byte, .i_last_byte,
        .i_route, .i_busy_req, .i_now, .i_link_active,
        .o_cmd_valid(cmd_valid), .o_cmd(cmd), .i_cmd_full(q_full)
    );

    nsfv_queue u_queue (
        .i_clk, .i_rst_n, .i_wr(cmd_valid), .i_cmd(cmd), .o_full(q_full),
        .o_valid(q_valid), .o_cmd(q_cmd), .i_rd(q_rd)
    );

    nsfv_back #(.MAX_MODE(MAX_MODE)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .i_cmd(q_cmd), .o_rd(q_rd),
        .i_timeout(r_timeout), .i_pop, .o_empty,
        .o_status_code, .o_status_id, .o_status_sequence, .o_position_valid,
        .o_latitude, .o_longitude, .o_accuracy, .o_off_route, .o_force_refresh,
        .o_refresh_mode
    );

endmodule

@@ tb/sv/nav_session_frame_validator_tb.sv @@
// nav_session_frame_validator_tb: self-checking bench for the frame validator
// depends on nsfv_pkg and nav_session_frame_validator; predicts each result
// from a behavioral copy of the session logic and compares field by field
`timescale 1ns / 1ps

module nav_session_frame_validator_tb;
    import nsfv_pkg::*;

    localparam int unsigned ModeMax = MaxModeDefault;
    localparam logic [1:0] RegTimeout = 2'd0;

    typedef struct packed {
        logic [2:0]  code;
        logic [31:0] id;
        logic [15:0] seq;
        logic        pos_valid;
        logic [30:0] lat;
        logic [31:0] lon;
        logic [5:0]  acc;
        logic        off_route;
        logic        force_refresh;
        logic [1:0]  mode;
    } t_status;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  func = FUNC_BYTE;
    logic [7:0]  data_byte = '0;
    logic        last_byte = 1'b0;
    logic [31:0] route = '0;
    logic        busy_req = 1'b0;
    logic [31:0] now_ms = '0;
    logic        link_active = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    t_status     dut_status;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    nav_session_frame_validator i_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_push(push), .o_full(full),
        .i_func(func), .i_data_byte(data_byte), .i_last_byte(last_byte),
        .i_route(route), .i_busy_req(busy_req), .i_now(now_ms),
        .i_link_active(link_active), .o_empty(empty), .i_pop(pop),
        .o_status_code(dut_status.code), .o_status_id(dut_status.id),
        .o_status_sequence(dut_status.seq), .o_position_valid(dut_status.pos_valid),
        .o_latitude(dut_status.lat), .o_longitude(dut_status.lon),
        .o_accuracy(dut_status.acc), .o_off_route(dut_status.off_route),
        .o_force_refresh(dut_status.force_refresh), .o_refresh_mode(dut_status.mode),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predicted session state
    logic [7:0]  rx_buf [FrameLen];
    logic [7:0]  fix_buf [FrameLen];
    int unsigned rx_len;
    logic        rx_match;
    logic        sess_on, have_fix, refresh_due;
    logic [1:0]  walk_mode;
    logic [31:0] sess_id, sess_route, stop_id, last_seen, timeout_ms;

    t_status     status_q [$];
    int          err_count = 0;
    int          send_idle = 0, recv_idle = 0;

    // session ids and routes used by well-formed frames
    logic [31:0] pick_id, pick_route;
    logic [15:0] pick_seq;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    function automatic logic [31:0] le32(input logic [7:0] b [FrameLen], input int p);
        return {b[p+3], b[p+2], b[p+1], b[p]};
    endfunction

    function automatic void drop_sess();
        sess_on = 1'b0;
        have_fix = 1'b0;
        refresh_due = 1'b0;
        walk_mode = ModeMax[1:0];
    endfunction

    function automatic void session_reset();
        rx_len = 0;
        rx_match = 1'b1;
        drop_sess();
        sess_id = '0;
        sess_route = '0;
        stop_id = '0;
        last_seen = '0;
        timeout_ms = TimeoutReset;
        for (int k = 0; k < FrameLen; k++) begin
            rx_buf[k] = '0;
            fix_buf[k] = '0;
        end
    endfunction

    function automatic logic [2:0] judge_frame(input int unsigned n, input logic match,
                                               input logic [31:0] rt, input logic bsy,
                                               input logic [31:0] tnow,
                                               output logic [31:0] id,
                                               output logic [15:0] seq);
        logic [1:0]   mode;
        logic signed [31:0] lat, lon;
        logic [15:0]  acc, age, adv;
        id = '0;
        seq = '0;
        if (n >= 5) begin
            if (rx_buf[0] == TYPE_START) begin
                if (n >= 10) id = le32(rx_buf, 6);
            end else begin
                id = le32(rx_buf, 1);
            end
        end
        if (n >= 7 && rx_buf[0] == TYPE_FIX) seq = {rx_buf[6], rx_buf[5]};
        if (id == 0) return ST_INVALID;
        if (rx_buf[0] == TYPE_START) begin
            mode = ModeMax[1:0];
            if (n == 10) begin
                if (rx_buf[1] != VER_1) return ST_INVALID;
            end else if (n == 11) begin
                if (rx_buf[1] != VER_2 || rx_buf[10] > ModeMax) return ST_INVALID;
                mode = rx_buf[10][1:0];
            end else begin
                return ST_INVALID;
            end
            if (rt == 0 || le32(rx_buf, 2) != rt || bsy) return ST_INVALID;
            if (sess_on) return (id == sess_id && rt == sess_route) ? ST_READY : ST_INVALID;
            if (id == sess_id || id == stop_id) return ST_INVALID;
            sess_id = id;
            sess_route = rt;
            sess_on = 1'b1;
            have_fix = 1'b0;
            walk_mode = mode;
            last_seen = tnow;
            return ST_READY;
        end
        if (rx_buf[0] == TYPE_STOP) begin
            if (n != 5) return ST_INVALID;
            if (!sess_on && id == stop_id) return ST_STOPPED;
            if (!sess_on || id != sess_id) return ST_INVALID;
            stop_id = id;
            drop_sess();
            return ST_STOPPED;
        end
        if (rx_buf[0] != TYPE_FIX || n != 20 || !sess_on || id != sess_id || bsy)
            return ST_INVALID;
        if (rt != sess_route) begin
            drop_sess();
            return ST_INVALID;
        end
        lat = le32(rx_buf, 7);
        lon = le32(rx_buf, 11);
        acc = {rx_buf[16], rx_buf[15]};
        age = {rx_buf[18], rx_buf[17]};
        if (lat < -900000000 || lat > 900000000 || lon < -1800000000 || lon > 1800000000
            || acc < 1 || acc > 50 || age > 15000 || rx_buf[19] > 3)
            return ST_INVALID;
        if (have_fix) begin
            adv = seq - {fix_buf[6], fix_buf[5]};
            if (adv == 0) return match ? ST_FIX : ST_INVALID;
            if (adv >= 16'd32768) return ST_INVALID;
        end
        for (int k = 0; k < FrameLen; k++) fix_buf[k] = rx_buf[k];
        have_fix = 1'b1;
        refresh_due = rx_buf[19][1];
        last_seen = tnow;
        return ST_FIX;
    endfunction

    // advances the predicted state by one accepted item; true if a result follows
    function automatic bit predict_status(input logic [1:0] f, input logic [7:0] b,
                                          input logic lst, input logic [31:0] rt,
                                          input logic bsy, input logic [31:0] tnow,
                                          input logic lnk, output t_status st);
        logic        m;
        int unsigned n;
        st = '0;
        if (f == FUNC_BYTE) begin
            m = rx_match;
            if (rx_len < 20) begin
                rx_buf[rx_len] = b;
                if (b != fix_buf[rx_len]) m = 1'b0;
            end
            n = rx_len < 31 ? rx_len + 1 : 31;
            if (!lst) begin
                rx_len = n;
                rx_match = m;
                return 0;
            end
            rx_len = 0;
            rx_match = 1'b1;
            st.code = judge_frame(n, m, rt, bsy, tnow, st.id, st.seq);
        end else if (f == FUNC_TICK) begin
            if (sess_on && !lnk && (tnow - last_seen) >= timeout_ms) drop_sess();
        end else if (f == FUNC_TAKE) begin
            st.code = ST_TAKEN;
            st.force_refresh = refresh_due;
            refresh_due = 1'b0;
        end else begin
            return 0;
        end
        if (sess_on && have_fix && lnk) begin
            st.pos_valid = 1'b1;
            st.lat = 31'(le32(fix_buf, 7));
            st.lon = le32(fix_buf, 11);
            st.acc = fix_buf[15][5:0];
            st.off_route = fix_buf[19][0];
        end
        st.mode = walk_mode;
        return 1;
    endfunction

    task automatic send_item(input logic [1:0] f, input logic [7:0] b, input logic lst,
                             input logic [31:0] rt, input logic bsy,
                             input logic [31:0] tnow, input logic lnk);
        t_status st;
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        func <= f;
        data_byte <= b;
        last_byte <= lst;
        route <= rt;
        busy_req <= bsy;
        now_ms <= tnow;
        link_active <= lnk;
        @(posedge clk);
        while (full) @(posedge clk);
        if (predict_status(f, b, lst, rt, bsy, tnow, lnk, st)) status_q.push_back(st);
    endtask

    task automatic send_frame(input logic [7:0] fb [$], input logic [31:0] rt,
                              input logic bsy, input logic [31:0] tnow, input logic lnk);
        foreach (fb[k]) send_item(FUNC_BYTE, fb[k], k == fb.size() - 1, rt, bsy, tnow, lnk);
    endtask

    function automatic void put32(ref logic [7:0] fb [$], input logic [31:0] v);
        for (int k = 0; k < 4; k++) fb.push_back(v[8*k +: 8]);
    endfunction

    task automatic send_start(input int ver, input logic [7:0] mode, input logic [31:0] id,
                              input logic [31:0] rt, input logic bsy, input logic [31:0] tnow);
        logic [7:0] fb [$];
        fb.push_back(TYPE_START);
        fb.push_back(ver == 2 ? VER_2 : VER_1);
        put32(fb, rt);
        put32(fb, id);
        if (ver == 2) fb.push_back(mode);
        send_frame(fb, rt, bsy, tnow, 1'b1);
    endtask

    task automatic send_stop(input logic [31:0] id, input logic [31:0] rt);
        logic [7:0] fb [$];
        fb.push_back(TYPE_STOP);
        put32(fb, id);
        send_frame(fb, rt, 1'b0, $urandom, 1'b1);
    endtask

    task automatic send_fix(input logic [31:0] id, input logic [15:0] seq,
                            input logic [31:0] lat, input logic [31:0] lon,
                            input logic [15:0] acc, input logic [15:0] age,
                            input logic [7:0] flags, input logic [31:0] rt,
                            input logic bsy, input logic [31:0] tnow, input logic lnk);
        logic [7:0] fb [$];
        fb.push_back(TYPE_FIX);
        put32(fb, id);
        fb.push_back(seq[7:0]);
        fb.push_back(seq[15:8]);
        put32(fb, lat);
        put32(fb, lon);
        fb.push_back(acc[7:0]);
        fb.push_back(acc[15:8]);
        fb.push_back(age[7:0]);
        fb.push_back(age[15:8]);
        fb.push_back(flags);
        send_frame(fb, rt, bsy, tnow, lnk);
    endtask

    task automatic wait_drain();
        int guard;
        guard = 0;
        push <= 1'b0;
        while (status_q.size() != 0 && guard < 20000) begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [31:0] v);
        wait_drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= RegTimeout;
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        timeout_ms = v;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // result checker
    always @(posedge clk) begin
        if (rst_n && pop && !empty) begin
            if (status_q.size() == 0) begin
                report_mismatch("unexpected result", dut_status.code, 0);
            end else begin
                t_status want;
                want = status_q.pop_front();
                if (dut_status.code !== want.code)
                    report_mismatch("status_code", dut_status.code, want.code);
                if (dut_status.id !== want.id) report_mismatch("status_id", dut_status.id, want.id);
                if (dut_status.seq !== want.seq)
                    report_mismatch("status_sequence", dut_status.seq, want.seq);
                if (dut_status.pos_valid !== want.pos_valid)
                    report_mismatch("position_valid", dut_status.pos_valid, want.pos_valid);
                if (dut_status.lat !== want.lat)
                    report_mismatch("latitude", dut_status.lat, want.lat);
                if (dut_status.lon !== want.lon)
                    report_mismatch("longitude", dut_status.lon, want.lon);
                if (dut_status.acc !== want.acc)
                    report_mismatch("accuracy", dut_status.acc, want.acc);
                if (dut_status.off_route !== want.off_route)
                    report_mismatch("off_route", dut_status.off_route, want.off_route);
                if (dut_status.force_refresh !== want.force_refresh)
                    report_mismatch("force_refresh", dut_status.force_refresh,
                                    want.force_refresh);
                if (dut_status.mode !== want.mode)
                    report_mismatch("refresh_mode", dut_status.mode, want.mode);
            end
        end
    end

    always @(posedge clk) begin
        pop <= (recv_idle == 0) || ($urandom_range(99) >= recv_idle);
    end

    function automatic logic [31:0] rand_lat();
        case ($urandom_range(3))
            0: return 32'sd900000000;
            1: return -32'sd900000000;
            default: return $urandom_range(1800000000) - 900000000;
        endcase
    endfunction

    function automatic logic [31:0] rand_lon();
        case ($urandom_range(3))
            0: return 32'sd1800000000;
            1: return -32'sd1800000000;
            default: return $urandom - 32'd0;
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] rt;
        rt = 32'hA5A5_0001;
        send_item(FUNC_TAKE, 8'hFF, 1'b1, '1, 1'b1, '1, 1'b1);
        send_item(FUNC_NONE, 8'h00, 1'b1, '0, 1'b0, '0, 1'b0);
        send_item(FUNC_TICK, 8'h00, 1'b0, '0, 1'b0, '1, 1'b0);
        send_start(2, 8'd3, 32'h11, rt, 1'b0, 32'd100);           // mode beyond limit
        send_start(2, 8'd0, 32'h11, rt, 1'b1, 32'd100);           // busy
        send_start(2, 8'd0, 32'h11, rt, 1'b0, 32'd100);
        send_start(1, 8'd0, 32'h11, rt, 1'b0, 32'd100);           // repeat start
        send_fix(32'h11, 16'd5, 32'sd900000000, -32'sd1800000000, 16'd50, 16'd15000,
                 8'h03, rt, 1'b0, 32'd200, 1'b1);
        send_fix(32'h11, 16'd5, 32'sd900000000, -32'sd1800000000, 16'd50, 16'd15000,
                 8'h03, rt, 1'b0, 32'd200, 1'b1);                 // duplicate
        send_fix(32'h11, 16'd4, 32'd0, 32'd0, 16'd1, 16'd0, 8'h00, rt, 1'b0, 32'd300, 1'b1);
        send_fix(32'h11, 16'd6, 32'd0, 32'd0, 16'd0, 16'd0, 8'h00, rt, 1'b0, 32'd300, 1'b1);
        send_item(FUNC_TAKE, 8'h00, 1'b0, rt, 1'b0, 32'd0, 1'b1);
        send_item(FUNC_TAKE, 8'h00, 1'b0, rt, 1'b0, 32'd0, 1'b0);
        // overlong frame saturates the length
        for (int k = 0; k < 34; k++)
            send_item(FUNC_BYTE, 8'(k), k == 33, rt, 1'b0, 32'd0, 1'b1);
        send_item(FUNC_TICK, 8'h00, 1'b0, rt, 1'b0, 32'd90199, 1'b0);
        send_item(FUNC_TICK, 8'h00, 1'b0, rt, 1'b0, 32'd90200, 1'b0);
        send_stop(32'h11, rt);
        send_stop(32'h11, rt);                                      // replay
        send_start(1, 8'd0, 32'h11, rt, 1'b0, 32'd500);           // stopped id
    endtask

    task automatic test_random_sessions(input int items);
        int sent;
        logic [31:0] t;
        sent = 0;
        t = $urandom;
        while (sent < items) begin
            t += $urandom_range(20000);
            case ($urandom_range(15))
                0, 1: begin
                    pick_id = $urandom_range(3) == 0 ? $urandom : $urandom_range(1, 4);
                    pick_route = $urandom_range(3) == 0 ? $urandom : $urandom_range(2);
                    send_start($urandom_range(1, 2), $urandom_range(3), pick_id, pick_route,
                               $urandom_range(9) == 0, t);
                    sent += 11;
                end
                2, 3, 4, 5, 6, 7: begin
                    pick_seq += $urandom_range(3) == 0 ? 16'($urandom) : $urandom_range(2);
                    send_fix($urandom_range(7) == 0 ? $urandom_range(1, 4) : pick_id,
                             pick_seq, rand_lat(), rand_lon(),
                             $urandom_range(9) == 0 ? $urandom : $urandom_range(1, 50),
                             $urandom_range(9) == 0 ? $urandom : $urandom_range(15000),
                             $urandom_range(9) == 0 ? $urandom : $urandom_range(3),
                             $urandom_range(9) == 0 ? $urandom_range(2) : pick_route,
                             $urandom_range(15) == 0, t, $urandom_range(4) != 0);
                    sent += 20;
                end
                8: begin
                    send_stop($urandom_range(3) == 0 ? $urandom_range(1, 4) : pick_id,
                              pick_route);
                    sent += 5;
                end
                9, 10: begin
                    send_item(FUNC_TICK, $urandom, $urandom, $urandom, $urandom, t,
                              $urandom_range(1));
                    sent++;
                end
                11, 12: begin
                    send_item(FUNC_TAKE, $urandom, $urandom, $urandom, $urandom, t,
                              $urandom_range(1));
                    sent++;
                end
                default: begin
                    // noise bytes of random length, including broken frames
                    for (int k = $urandom_range(1, 24); k > 0; k--) begin
                        send_item($urandom_range(9) == 0 ? FUNC_NONE : FUNC_BYTE, $urandom,
                                  k == 1, $urandom, $urandom, t, $urandom);
                        sent++;
                    end
                end
            endcase
        end
    endtask

    task automatic test_timeout_settings();
        write_timeout(32'd0);
        test_random_sessions(100);
        write_timeout(32'hFFFF_FFFF);
        test_random_sessions(100);
        write_timeout(32'd20000);
    endtask

    initial begin
        session_reset();
        pick_id = 32'd1;
        pick_route = 32'd1;
        pick_seq = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_timeout_settings();
        send_idle = 35;
        recv_idle = 52;
        test_random_sessions(330);
        send_idle = 52;
        recv_idle = 35;
        test_random_sessions(330);
        send_idle = 0;
        recv_idle = 0;
        test_random_sessions(330);
        wait_drain();
        if (status_q.size() != 0) begin
            report_mismatch("results missing", status_q.size(), 0);
        end
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
